FILE: hdl/gre_hp_pkg.sv
// Package for the GRE header parser: parse phases, flag masks, result layout
// and the small helper functions for field presence and header checks.
// Used by gre_header_parser; depends on nothing else.
package gre_hp_pkg;

    // Largest number of bytes of one packet that are parsed and summed.
    localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;

    // Flags halfword bits.
    localparam logic [15:0] FLG_C      = 16'h8000;
    localparam logic [15:0] FLG_R      = 16'h4000;
    localparam logic [15:0] FLG_K      = 16'h2000;
    localparam logic [15:0] FLG_S      = 16'h1000;
    localparam logic [15:0] FLG_STRICT = 16'h0800;
    localparam logic [15:0] FLG_RECUR  = 16'h0700;
    localparam logic [15:0] FLG_A      = 16'h0080;
    localparam logic [15:0] FLG_VER    = 16'h0007;
    localparam logic [15:0] FLG_RSV_V0 = 16'h00f8;
    localparam logic [15:0] FLG_RSV_V1 = 16'h0078;

    localparam logic [2:0]  VER_BASIC    = 3'd0;
    localparam logic [2:0]  VER_ENHANCED = 3'd1;
    localparam logic [15:0] PROTO_PPP    = 16'h880b;

    // Result word width on the output stream.
    localparam int RESULT_W = 192;

    typedef enum logic [3:0] {
        PH_BASE    = 4'd0,
        PH_CSUM    = 4'd1,
        PH_KEY     = 4'd2,
        PH_SEQ     = 4'd3,
        PH_ACK     = 4'd4,
        PH_RHDR    = 4'd5,
        PH_RDATA   = 4'd6,
        PH_PAYLOAD = 4'd7
    } t_phase;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [4:0]  pad;
        logic        aborted;
        logic        malformed;
        logic        sum_ok;
        logic [15:0] payload_start;
        logic [7:0]  route_entries;
        logic [31:0] ack_value;
        logic [31:0] sequence_value;
        logic [31:0] key_value;
        logic [15:0] route_offset_field;
        logic [15:0] checksum_field;
        logic [15:0] protocol_word;
        logic [15:0] flags_word;
    } t_result;

    // True when the optional field of phase q follows the base header.
    function automatic logic f_present(input t_phase q, input logic [15:0] flags);
        logic [2:0] ver;
        logic       res;
        ver = flags[2:0];
        res = 1'b0;
        if (ver == VER_BASIC) begin
            case (q)
                PH_CSUM: res = (flags & (FLG_C | FLG_R)) != 16'd0;
                PH_KEY:  res = (flags & FLG_K) != 16'd0;
                PH_SEQ:  res = (flags & FLG_S) != 16'd0;
                PH_RHDR: res = (flags & FLG_R) != 16'd0;
                default: res = 1'b0;
            endcase
        end else if (ver == VER_ENHANCED) begin
            case (q)
                PH_KEY:  res = (flags & FLG_K) != 16'd0;
                PH_SEQ:  res = (flags & FLG_S) != 16'd0;
                PH_ACK:  res = (flags & FLG_A) != 16'd0;
                default: res = 1'b0;
            endcase
        end
        return res;
    endfunction

    // First present phase after the current one, else the payload.
    function automatic t_phase f_next_phase(input t_phase cur, input logic [15:0] flags);
        t_phase res;
        if (cur < PH_CSUM && f_present(PH_CSUM, flags)) begin
            res = PH_CSUM;
        end else if (cur < PH_KEY && f_present(PH_KEY, flags)) begin
            res = PH_KEY;
        end else if (cur < PH_SEQ && f_present(PH_SEQ, flags)) begin
            res = PH_SEQ;
        end else if (cur < PH_ACK && f_present(PH_ACK, flags)) begin
            res = PH_ACK;
        end else if (cur < PH_RHDR && f_present(PH_RHDR, flags)) begin
            res = PH_RHDR;
        end else begin
            res = PH_PAYLOAD;
        end
        return res;
    endfunction

    // Checks on the completed base header.
    function automatic logic f_base_bad(input logic [15:0] flags, input logic [15:0] proto);
        logic res;
        if (flags[2:0] == VER_BASIC) begin
            res = ((flags & FLG_RSV_V0) != 16'd0) ||
                  (((flags & FLG_STRICT) != 16'd0) && ((flags & FLG_R) == 16'd0));
        end else if (flags[2:0] == VER_ENHANCED) begin
            res = (proto != PROTO_PPP) ||
                  ((flags & (FLG_C | FLG_R | FLG_STRICT | FLG_RECUR | FLG_RSV_V1)) != 16'd0);
        end else begin
            res = 1'b1;
        end
        return res;
    endfunction

endpackage

FILE: hdl/gre_header_parser.sv
// GRE header parser top level: byte stream in, one summary word per packet out.
// Depends on gre_hp_pkg for phases, masks, the result layout and helpers.
//
// Usage:
// The slave stream takes one packet byte per word in i_s_tdata[7:0], wire order
// from the GRE header start, with i_s_tlast on the final byte. The master stream
// gives one result word per packet, sent for the word that carried tlast.
// Each accepted word goes into an input register; from there the parse
// state (phase, byte position, header fields, route walk, ones-complement sum)
// is updated by one pass of logic, and for a last byte the summary is written
// to the output register, which drives o_m_tvalid. Throughput is one byte per
// cycle, set by the single state update per byte, while no last byte waits
// in the input register for the output register to be freed.
// When the receiver stalls, the result stays in the output register; bytes that
// are not last keep flowing, and a last byte waits in the input register until
// the output register is free, which then holds o_s_tready low.
// Reset (synchronous, active low) empties both registers and returns the parse
// state to the base-header phase with all fields cleared; the same happens to
// the parse state after each last byte.
module gre_header_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [7:0]                       i_s_tdata,  // data_byte
    input  logic                             i_s_tlast,  // end_of_packet
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // From bit 0: flags_word, protocol_word, checksum_field, route_offset_field,
    // key_value, sequence_value, ack_value, route_entries, payload_start,
    // sum_ok, malformed, aborted, zero padding.
    output logic [gre_hp_pkg::RESULT_W-1:0]  o_m_tdata
);
    import gre_hp_pkg::*;

    // Input register.
    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // Parse state.
    logic [15:0] r_position, n_position;
    t_phase      r_phase, n_phase;
    logic [15:0] r_flag, n_flag;
    logic [15:0] r_proto, n_proto;
    logic [15:0] r_csum_field, n_csum_field;
    logic [15:0] r_roff_field, n_roff_field;
    logic [31:0] r_key, n_key;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_ack, n_ack;
    logic [2:0]  r_field_bytes, n_field_bytes;
    logic [31:0] r_route_head, n_route_head;
    logic [7:0]  r_route_left, n_route_left;
    logic [7:0]  r_route_count, n_route_count;
    logic [15:0] r_ones_sum, n_ones_sum;
    logic        r_odd_pend, n_odd_pend;
    logic [7:0]  r_odd_byte, n_odd_byte;
    logic [15:0] r_payload_at, n_payload_at;
    logic        r_bad, n_bad;
    logic        r_stop, n_stop;

    // Output register.
    logic        r_out_valid, n_out_valid;
    t_result     r_res, n_res;

    logic        w_out_free;
    logic        w_adv;

    // The input register moves on unless a last byte finds the output full.
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_adv      = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_tready = !r_in_valid || w_adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_res;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_s_tvalid && o_s_tready) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
    end

    // Per-byte state update and the summary on the last byte.
    always_comb begin
        logic        parse_en;
        logic        enter;
        logic        add_en;
        logic [15:0] add_word;
        logic [16:0] sum_raw;
        logic        mal;
        logic        abt;
        logic        sok;
        logic [15:0] pay_len;

        n_position    = r_position;
        n_phase       = r_phase;
        n_flag        = r_flag;
        n_proto       = r_proto;
        n_csum_field  = r_csum_field;
        n_roff_field  = r_roff_field;
        n_key         = r_key;
        n_seq         = r_seq;
        n_ack         = r_ack;
        n_field_bytes = r_field_bytes;
        n_route_head  = r_route_head;
        n_route_left  = r_route_left;
        n_route_count = r_route_count;
        n_ones_sum    = r_ones_sum;
        n_odd_pend    = r_odd_pend;
        n_odd_byte    = r_odd_byte;
        n_payload_at  = r_payload_at;
        n_bad         = r_bad;
        n_stop        = r_stop;
        n_res         = r_res;
        n_out_valid   = r_out_valid && !i_m_tready;

        parse_en = (r_position != MAX_PACKET_BYTES);
        enter    = 1'b0;
        add_en   = 1'b0;
        add_word = 16'd0;
        mal      = 1'b0;
        abt      = 1'b0;
        sok      = 1'b0;
        pay_len  = 16'd0;

        if (w_adv) begin
            if (!parse_en) begin
                // Oversize packet: the byte is dropped.
                n_stop = 1'b1;
                n_bad  = 1'b1;
            end else begin
                n_position = r_position + 16'd1;

                // Pair bytes into 16-bit words for the checksum.
                if (r_odd_pend) begin
                    add_en     = 1'b1;
                    add_word   = {r_odd_byte, r_in_byte};
                    n_odd_pend = 1'b0;
                end else begin
                    n_odd_pend = 1'b1;
                    n_odd_byte = r_in_byte;
                end

                n_field_bytes = r_field_bytes + 3'd1;
                case (r_phase)
                    PH_BASE: begin
                        if (r_field_bytes < 3'd2) begin
                            n_flag = {r_flag[7:0], r_in_byte};
                        end else begin
                            n_proto = {r_proto[7:0], r_in_byte};
                        end
                        if (r_field_bytes == 3'd3) begin
                            n_bad = r_bad || f_base_bad(n_flag, n_proto);
                            enter = 1'b1;
                        end
                    end
                    PH_CSUM: begin
                        if (r_field_bytes < 3'd2) begin
                            n_csum_field = {r_csum_field[7:0], r_in_byte};
                        end else begin
                            n_roff_field = {r_roff_field[7:0], r_in_byte};
                        end
                        enter = (r_field_bytes == 3'd3);
                    end
                    PH_KEY: begin
                        n_key = {r_key[23:0], r_in_byte};
                        enter = (r_field_bytes == 3'd3);
                    end
                    PH_SEQ: begin
                        n_seq = {r_seq[23:0], r_in_byte};
                        enter = (r_field_bytes == 3'd3);
                    end
                    PH_ACK: begin
                        n_ack = {r_ack[23:0], r_in_byte};
                        enter = (r_field_bytes == 3'd3);
                    end
                    PH_RHDR: begin
                        n_route_head = {r_route_head[23:0], r_in_byte};
                        if (r_field_bytes == 3'd3) begin
                            if (r_route_count != 8'hff) begin
                                n_route_count = r_route_count + 8'd1;
                            end
                            if (n_route_head[31:16] == 16'd0 && n_route_head[7:0] == 8'd0) begin
                                // Terminator entry ends the route list.
                                if (n_route_head[15:8] != 8'd0) begin
                                    n_bad = 1'b1;
                                end
                                enter = 1'b1;
                            end else if (n_route_head[7:0] != 8'd0) begin
                                n_route_left = n_route_head[7:0];
                                n_phase      = PH_RDATA;
                            end else begin
                                n_field_bytes = 3'd0;
                            end
                        end
                    end
                    PH_RDATA: begin
                        n_field_bytes = r_field_bytes;
                        n_route_left  = r_route_left - 8'd1;
                        if (n_route_left == 8'd0) begin
                            n_phase       = PH_RHDR;
                            n_field_bytes = 3'd0;
                        end
                    end
                    default: begin
                        n_field_bytes = r_field_bytes;
                    end
                endcase

                if (enter) begin
                    n_phase       = f_next_phase(r_phase, n_flag);
                    n_field_bytes = 3'd0;
                    if (n_phase == PH_PAYLOAD) begin
                        n_payload_at = n_position;
                    end
                end
            end

            // A byte left unpaired at the end is padded with zero.
            if (r_in_last && n_odd_pend) begin
                add_en   = 1'b1;
                add_word = {n_odd_byte, 8'h00};
            end
        end

        // Ones-complement add with end-around carry.
        sum_raw = {1'b0, r_ones_sum} + {1'b0, add_word};
        if (add_en) begin
            n_ones_sum = sum_raw[15:0] + {15'd0, sum_raw[16]};
        end

        if (w_adv && r_in_last) begin
            // Summary checks on the final state of the packet.
            mal     = n_bad;
            abt     = n_stop;
            pay_len = n_position - n_payload_at;
            if (n_phase != PH_PAYLOAD) begin
                abt = 1'b1;
                if (n_phase == PH_RHDR || n_phase == PH_RDATA) begin
                    mal = 1'b1;
                end
            end else if (!n_stop) begin
                if (n_flag[2:0] == VER_BASIC && n_payload_at == n_position &&
                    n_proto != 16'd0) begin
                    mal = 1'b1;
                end
                if (n_flag[2:0] == VER_ENHANCED && (n_flag & FLG_K) != 16'd0 &&
                    n_key[31:16] > pay_len) begin
                    mal = 1'b1;
                    abt = 1'b1;
                end
            end
            sok = (n_phase != PH_BASE) && (n_phase != PH_CSUM) &&
                  (n_flag[2:0] == VER_BASIC) && ((n_flag & FLG_C) != 16'd0) &&
                  !n_stop && (n_ones_sum == 16'hffff);

            n_res.pad                = 5'd0;
            n_res.aborted            = abt;
            n_res.malformed          = mal;
            n_res.sum_ok             = sok;
            n_res.payload_start      = n_payload_at;
            n_res.route_entries      = n_route_count;
            n_res.ack_value          = n_ack;
            n_res.sequence_value     = n_seq;
            n_res.key_value          = n_key;
            n_res.route_offset_field = n_roff_field;
            n_res.checksum_field     = n_csum_field;
            n_res.protocol_word      = n_proto;
            n_res.flags_word         = n_flag;
            n_out_valid              = 1'b1;

            // Back to the start-of-packet state.
            n_position    = 16'd0;
            n_phase       = PH_BASE;
            n_flag        = 16'd0;
            n_proto       = 16'd0;
            n_csum_field  = 16'd0;
            n_roff_field  = 16'd0;
            n_key         = 32'd0;
            n_seq         = 32'd0;
            n_ack         = 32'd0;
            n_field_bytes = 3'd0;
            n_route_head  = 32'd0;
            n_route_left  = 8'd0;
            n_route_count = 8'd0;
            n_ones_sum    = 16'd0;
            n_odd_pend    = 1'b0;
            n_odd_byte    = 8'd0;
            n_payload_at  = 16'd0;
            n_bad         = 1'b0;
            n_stop        = 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        r_res <= n_res;
    end

    // Control and parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_position    <= 16'd0;
            r_phase       <= PH_BASE;
            r_flag        <= 16'd0;
            r_proto       <= 16'd0;
            r_csum_field  <= 16'd0;
            r_roff_field  <= 16'd0;
            r_key         <= 32'd0;
            r_seq         <= 32'd0;
            r_ack         <= 32'd0;
            r_field_bytes <= 3'd0;
            r_route_head  <= 32'd0;
            r_route_left  <= 8'd0;
            r_route_count <= 8'd0;
            r_ones_sum    <= 16'd0;
            r_odd_pend    <= 1'b0;
            r_odd_byte    <= 8'd0;
            r_payload_at  <= 16'd0;
            r_bad         <= 1'b0;
            r_stop        <= 1'b0;
        end else begin
            r_in_valid    <= n_in_valid;
            r_out_valid   <= n_out_valid;
            r_position    <= n_position;
            r_phase       <= n_phase;
            r_flag        <= n_flag;
            r_proto       <= n_proto;
            r_csum_field  <= n_csum_field;
            r_roff_field  <= n_roff_field;
            r_key         <= n_key;
            r_seq         <= n_seq;
            r_ack         <= n_ack;
            r_field_bytes <= n_field_bytes;
            r_route_head  <= n_route_head;
            r_route_left  <= n_route_left;
            r_route_count <= n_route_count;
            r_ones_sum    <= n_ones_sum;
            r_odd_pend    <= n_odd_pend;
            r_odd_byte    <= n_odd_byte;
            r_payload_at  <= n_payload_at;
            r_bad         <= n_bad;
            r_stop        <= n_stop;
        end
    end

`ifndef SYNTHESIS
    // A last byte leaves the parser at the start of a new packet.
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> (r_position == 16'd0 && r_phase == PH_BASE))
        else $error("parse state not cleared after last byte");

    // Route data phase always has bytes left to skip.
    a_rdata_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RDATA) |-> (r_route_left != 8'd0))
        else $error("route data phase with nothing left");

    // The payload start lies inside the bytes already seen.
    a_payload_at: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_payload_at != 16'd0 && r_payload_at <= r_position))
        else $error("payload start beyond byte position");

    // A new result is never written over one still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> $stable(r_res))
        else $error("pending result overwritten");
`endif

endmodule

FILE: verif/gre_header_parser_test.sv
// Self-checking testbench for gre_header_parser: GRE packets go in one byte per word
// and each per-packet summary word is checked against a predictor of the parser.
// Depends on gre_hp_pkg and gre_header_parser; needs no other file.
module gre_header_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gre_hp_pkg::*;

    localparam int unsigned RANDOM_BYTES     = 200;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES     = 16;
    localparam int unsigned MAX_PRINTED      = 40;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata  = 8'h00;  // data_byte
    logic                i_s_tlast  = 1'b0;   // end_of_packet
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [RESULT_W-1:0] o_m_tdata;           // summary fields, flags_word at bit 0

    // Stimulus control shared by the sender and the receiver.
    bit                  steady_flow  = 1'b0;
    bit                  hold_request = 1'b0;
    logic [7:0]          pkt_bytes[$];

    // Expected summaries, oldest first, and the failure count.
    t_result             expected_summaries[$];
    int unsigned         mismatch_count    = 0;
    int unsigned         summaries_checked = 0;

    // Predictor copy of the parse state for the packet in flight.
    int unsigned         pos_count;
    t_phase              hdr_phase;
    logic [15:0]         hdr_flags, hdr_proto, hdr_csum, hdr_roff;
    logic [31:0]         hdr_key, hdr_seq, hdr_ack, route_word;
    logic [2:0]          field_count;
    logic [7:0]          route_bytes_left, route_seen;
    logic [15:0]         sum_acc;
    logic [8:0]          held_byte;
    logic [15:0]         payload_offset;
    logic                saw_bad, saw_stop;

    gre_header_parser dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------

    function automatic void clear_parse_state();
        pos_count        = 0;
        hdr_phase        = PH_BASE;
        hdr_flags        = '0;
        hdr_proto        = '0;
        hdr_csum         = '0;
        hdr_roff         = '0;
        hdr_key          = '0;
        hdr_seq          = '0;
        hdr_ack          = '0;
        route_word       = '0;
        field_count      = '0;
        route_bytes_left = '0;
        route_seen       = '0;
        sum_acc          = '0;
        held_byte        = '0;
        payload_offset   = '0;
        saw_bad          = 1'b0;
        saw_stop         = 1'b0;
    endfunction

    // Whether the flags announce the optional field handled in phase q.
    function automatic logic field_follows(input t_phase q);
        logic [2:0] ver;
        ver = hdr_flags[2:0];
        if (ver == VER_BASIC) begin
            case (q)
                PH_CSUM: return (hdr_flags & (FLG_C | FLG_R)) != 16'd0;
                PH_KEY:  return (hdr_flags & FLG_K) != 16'd0;
                PH_SEQ:  return (hdr_flags & FLG_S) != 16'd0;
                PH_RHDR: return (hdr_flags & FLG_R) != 16'd0;
                default: return 1'b0;
            endcase
        end
        if (ver == VER_ENHANCED) begin
            case (q)
                PH_KEY:  return (hdr_flags & FLG_K) != 16'd0;
                PH_SEQ:  return (hdr_flags & FLG_S) != 16'd0;
                PH_ACK:  return (hdr_flags & FLG_A) != 16'd0;
                default: return 1'b0;
            endcase
        end
        return 1'b0;
    endfunction

    // Move to the next announced field, or to the payload.
    function automatic void skip_to_next_field();
        logic [3:0] q;
        q = 4'(hdr_phase) + 4'd1;
        while (q < 4'(PH_PAYLOAD) && !field_follows(t_phase'(q))) begin
            q = q + 4'd1;
        end
        hdr_phase   = t_phase'(q);
        field_count = '0;
        if (hdr_phase == PH_PAYLOAD) begin
            payload_offset = 16'(pos_count + 1);
        end
    endfunction

    function automatic void add_ones_word(input logic [15:0] w);
        logic [16:0] s;
        s       = {1'b0, sum_acc} + {1'b0, w};
        sum_acc = s[15:0] + {15'd0, s[16]};
    endfunction

    // Rules on the completed base header.
    function automatic void check_base_header();
        if (hdr_flags[2:0] == VER_BASIC) begin
            if ((hdr_flags & FLG_RSV_V0) != 16'd0 ||
                ((hdr_flags & FLG_STRICT) != 16'd0 && (hdr_flags & FLG_R) == 16'd0)) begin
                saw_bad = 1'b1;
            end
        end else if (hdr_flags[2:0] == VER_ENHANCED) begin
            if (hdr_proto != PROTO_PPP ||
                (hdr_flags & (FLG_C | FLG_R | FLG_STRICT | FLG_RECUR | FLG_RSV_V1)) != 16'd0) begin
                saw_bad = 1'b1;
            end
        end else begin
            saw_bad = 1'b1;
        end
    endfunction

    function automatic void parse_one_byte(input logic [7:0] b);
        // The running sum pairs bytes into big-endian halfwords.
        if (held_byte[8]) begin
            add_ones_word({held_byte[7:0], b});
            held_byte = '0;
        end else begin
            held_byte = {1'b1, b};
        end
        case (hdr_phase)
            PH_BASE: begin
                if (field_count < 3'd2) hdr_flags = {hdr_flags[7:0], b};
                else hdr_proto = {hdr_proto[7:0], b};
                field_count++;
                if (field_count == 3'd4) begin
                    check_base_header();
                    skip_to_next_field();
                end
            end
            PH_CSUM: begin
                if (field_count < 3'd2) hdr_csum = {hdr_csum[7:0], b};
                else hdr_roff = {hdr_roff[7:0], b};
                field_count++;
                if (field_count == 3'd4) skip_to_next_field();
            end
            PH_KEY: begin
                hdr_key = {hdr_key[23:0], b};
                field_count++;
                if (field_count == 3'd4) skip_to_next_field();
            end
            PH_SEQ: begin
                hdr_seq = {hdr_seq[23:0], b};
                field_count++;
                if (field_count == 3'd4) skip_to_next_field();
            end
            PH_ACK: begin
                hdr_ack = {hdr_ack[23:0], b};
                field_count++;
                if (field_count == 3'd4) skip_to_next_field();
            end
            PH_RHDR: begin
                // Entry head: family halfword, offset byte, length byte.
                route_word = {route_word[23:0], b};
                field_count++;
                if (field_count == 3'd4) begin
                    if (route_seen != 8'hFF) route_seen++;
                    if (route_word[31:16] == 16'd0 && route_word[7:0] == 8'd0) begin
                        if (route_word[15:8] != 8'd0) saw_bad = 1'b1;
                        skip_to_next_field();
                    end else if (route_word[7:0] != 8'd0) begin
                        route_bytes_left = route_word[7:0];
                        hdr_phase        = PH_RDATA;
                    end else begin
                        field_count = '0;
                    end
                end
            end
            PH_RDATA: begin
                route_bytes_left--;
                if (route_bytes_left == 8'd0) begin
                    hdr_phase   = PH_RHDR;
                    field_count = '0;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Advance by one accepted byte; returns 1 with the summary on the last byte.
    function automatic bit track_byte(input logic [7:0] b, input logic last,
                                      output t_result summary);
        logic        mal, abt, sok;
        logic [2:0]  ver;
        int unsigned after_header;
        summary = '0;
        if (pos_count >= 32'(MAX_PACKET_BYTES)) begin
            saw_stop = 1'b1;
            saw_bad  = 1'b1;
        end else begin
            parse_one_byte(b);
            pos_count++;
        end
        if (!last) return 1'b0;

        if (held_byte[8]) add_ones_word({held_byte[7:0], 8'h00});
        mal = saw_bad;
        abt = saw_stop;
        sok = 1'b0;
        ver = hdr_flags[2:0];
        after_header = pos_count - 32'(payload_offset);
        if (hdr_phase != PH_PAYLOAD) begin
            abt = 1'b1;
            if (hdr_phase == PH_RHDR || hdr_phase == PH_RDATA) mal = 1'b1;
        end else if (!saw_stop) begin
            if (ver == VER_BASIC && 32'(payload_offset) == pos_count && hdr_proto != 16'd0) begin
                mal = 1'b1;
            end
            if (ver == VER_ENHANCED && (hdr_flags & FLG_K) != 16'd0 &&
                32'(hdr_key[31:16]) > after_header) begin
                mal = 1'b1;
                abt = 1'b1;
            end
        end
        if (hdr_phase > PH_CSUM && ver == VER_BASIC && (hdr_flags & FLG_C) != 16'd0 &&
            !saw_stop && sum_acc == 16'hFFFF) begin
            sok = 1'b1;
        end

        summary.flags_word         = hdr_flags;
        summary.protocol_word      = hdr_proto;
        summary.checksum_field     = hdr_csum;
        summary.route_offset_field = hdr_roff;
        summary.key_value          = hdr_key;
        summary.sequence_value     = hdr_seq;
        summary.ack_value          = hdr_ack;
        summary.route_entries      = route_seen;
        summary.payload_start      = payload_offset;
        summary.sum_ok             = sok;
        summary.malformed          = mal;
        summary.aborted            = abt;
        clear_parse_state();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("packet %0d: %s got %h expected %h", summaries_checked, what, got, want);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    // Predict on each accepted byte and compare each accepted summary word.
    initial clear_parse_state();

    always @(posedge i_clk) begin : summary_check
        t_result want_sum;
        t_result got_sum;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                if (track_byte(i_s_tdata, i_s_tlast, want_sum)) begin
                    expected_summaries.push_back(want_sum);
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                got_sum = t_result'(o_m_tdata);
                if (expected_summaries.size() == 0) begin
                    report_mismatch("summary with no packet pending",
                                    32'(got_sum.flags_word), 32'd0);
                end else begin
                    want_sum = expected_summaries.pop_front();
                    check_field("flags_word", 32'(got_sum.flags_word),
                                32'(want_sum.flags_word));
                    check_field("protocol_word", 32'(got_sum.protocol_word),
                                32'(want_sum.protocol_word));
                    check_field("checksum_field", 32'(got_sum.checksum_field),
                                32'(want_sum.checksum_field));
                    check_field("route_offset_field", 32'(got_sum.route_offset_field),
                                32'(want_sum.route_offset_field));
                    check_field("key_value", got_sum.key_value, want_sum.key_value);
                    check_field("sequence_value", got_sum.sequence_value,
                                want_sum.sequence_value);
                    check_field("ack_value", got_sum.ack_value, want_sum.ack_value);
                    check_field("route_entries", 32'(got_sum.route_entries),
                                32'(want_sum.route_entries));
                    check_field("payload_start", 32'(got_sum.payload_start),
                                32'(want_sum.payload_start));
                    check_field("sum_ok", 32'(got_sum.sum_ok), 32'(want_sum.sum_ok));
                    check_field("malformed", 32'(got_sum.malformed),
                                32'(want_sum.malformed));
                    check_field("aborted", 32'(got_sum.aborted), 32'(want_sum.aborted));
                end
                summaries_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake drivers
    // ------------------------------------------------------------------

    // Idle length: mostly none, often short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady_flow || roll < 55) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: alternating ready and stall runs, or one long hold on request.
    int unsigned ready_run = 0;
    int unsigned hold_left = 0;
    bit          ready_on  = 1'b0;

    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (steady_flow) begin
            i_m_tready <= 1'b1;
        end else begin
            if (ready_run == 0) begin
                ready_on  = !ready_on;
                ready_run = ready_on ? $urandom_range(1, 12) : 1 + pick_gap();
            end
            ready_run--;
            i_m_tready <= ready_on;
        end
    end

    // Offer one byte after a random gap and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt_bytes.size(); i++) begin
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        end
    endtask

    task automatic stop_sending();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Packet construction
    // ------------------------------------------------------------------

    function automatic void push16(input logic [15:0] v);
        pkt_bytes.push_back(v[15:8]);
        pkt_bytes.push_back(v[7:0]);
    endfunction

    function automatic void push32(input logic [31:0] v);
        push16(v[31:16]);
        push16(v[15:0]);
    endfunction

    function automatic int unsigned pick_payload_len();
        return ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
    endfunction

    // Header with the fields the flags announce, then random payload bytes.
    // With fix_sum a version 0 checksum is made valid over the whole packet.
    function automatic void build_packet(input logic [15:0] flags, input logic [15:0] proto,
                                         input int unsigned n_routes,
                                         input int unsigned route_len_max,
                                         input int unsigned n_payload, input bit fix_sum);
        int unsigned i, len;
        logic [15:0] fam, total;
        logic [16:0] s;
        logic [7:0]  lo;
        pkt_bytes.delete();
        push16(flags);
        push16(proto);
        if (flags[2:0] == VER_BASIC) begin
            if ((flags & (FLG_C | FLG_R)) != 16'd0) begin
                push16(16'($urandom));
                push16(16'($urandom));
            end
            if ((flags & FLG_K) != 16'd0) push32($urandom);
            if ((flags & FLG_S) != 16'd0) push32($urandom);
            if ((flags & FLG_R) != 16'd0) begin
                for (i = 0; i < n_routes; i++) begin
                    len = $urandom_range(0, route_len_max);
                    fam = 16'($urandom);
                    if (fam == 16'd0 && len == 0) fam = 16'h0001;
                    push16(fam);
                    pkt_bytes.push_back(8'($urandom));
                    pkt_bytes.push_back(8'(len));
                    repeat (len) pkt_bytes.push_back(8'($urandom));
                end
                // Terminator, now and then with a stray offset.
                push16(16'h0000);
                pkt_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                                                : 8'h00);
                pkt_bytes.push_back(8'h00);
            end
        end else if (flags[2:0] == VER_ENHANCED) begin
            if ((flags & FLG_K) != 16'd0) begin
                push16(($urandom_range(0, 5) == 0) ? 16'(n_payload + $urandom_range(1, 8))
                                                   : 16'($urandom_range(0, n_payload)));
                push16(16'($urandom));
            end
            if ((flags & FLG_S) != 16'd0) push32($urandom);
            if ((flags & FLG_A) != 16'd0) push32($urandom);
        end
        repeat (n_payload) pkt_bytes.push_back(8'($urandom));

        if (fix_sum && flags[2:0] == VER_BASIC && (flags & FLG_C) != 16'd0) begin
            pkt_bytes[4] = 8'h00;
            pkt_bytes[5] = 8'h00;
            total = '0;
            for (i = 0; i < pkt_bytes.size(); i += 2) begin
                lo    = (i + 1 < pkt_bytes.size()) ? pkt_bytes[i + 1] : 8'h00;
                s     = {1'b0, total} + {1'b0, pkt_bytes[i], lo};
                total = s[15:0] + {15'd0, s[16]};
            end
            total        = ~total;
            pkt_bytes[4] = total[15:8];
            pkt_bytes[5] = total[7:0];
        end
    endfunction

    // Mostly well-formed version 0 and 1 packets, some other versions,
    // some cut short and some pure noise.
    function automatic void build_random_packet();
        int unsigned kind, cut;
        logic [15:0] flags, proto;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            flags = 16'($urandom) & (FLG_C | FLG_R | FLG_K | FLG_S);
            if ($urandom_range(0, 7) == 0) begin
                flags |= 16'($urandom) & (FLG_STRICT | FLG_RECUR | FLG_RSV_V0);
            end
            proto = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
            build_packet(flags, proto, $urandom_range(0, 3), 10, pick_payload_len(),
                         $urandom_range(0, 3) != 0);
        end else if (kind < 80) begin
            flags = 16'(VER_ENHANCED) | (16'($urandom) & (FLG_K | FLG_S | FLG_A));
            if ($urandom_range(0, 7) == 0) begin
                flags |= 16'($urandom) & (FLG_C | FLG_R | FLG_STRICT | FLG_RECUR | FLG_RSV_V1);
            end
            proto = ($urandom_range(0, 7) == 0) ? 16'($urandom) : PROTO_PPP;
            build_packet(flags, proto, 0, 0, pick_payload_len(), 1'b0);
        end else if (kind < 88) begin
            flags = (16'($urandom) & ~FLG_VER) | 16'($urandom_range(2, 7));
            build_packet(flags, 16'($urandom), 0, 0, pick_payload_len(), 1'b0);
        end else begin
            pkt_bytes.delete();
            repeat ($urandom_range(1, 24)) pkt_bytes.push_back(8'($urandom));
        end
        if (kind < 88 && pkt_bytes.size() > 1 && $urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, pkt_bytes.size() - 1);
            while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_header_corners();
        // A lone byte ends the packet inside the base header.
        pkt_bytes.delete();
        pkt_bytes.push_back(8'hFF);
        send_packet();
        // Bare base header with a zero protocol word and no payload.
        build_packet(16'h0000, 16'h0000, 0, 0, 0, 1'b0);
        send_packet();
        // Empty payload behind a nonzero protocol word.
        build_packet(16'h0000, 16'h0800, 0, 0, 0, 1'b0);
        send_packet();
        // Every flag set and an unknown version.
        build_packet(16'hFFFF, 16'hFFFF, 0, 0, 1, 1'b0);
        send_packet();
        // Valid checksum over an odd number of bytes.
        build_packet(FLG_C, 16'h0800, 0, 0, 3, 1'b1);
        send_packet();
        // Route walk that stops on an entry boundary without a terminator.
        build_packet(FLG_R, 16'h0800, 1, 2, 0, 1'b0);
        repeat (4) void'(pkt_bytes.pop_back());
        send_packet();
        // Terminator that carries a nonzero offset.
        build_packet(FLG_R, 16'h6558, 0, 0, 2, 1'b0);
        pkt_bytes[10] = 8'h04;
        send_packet();
        // Enhanced GRE that declares more payload than it carries.
        build_packet(16'(VER_ENHANCED) | FLG_K | FLG_S | FLG_A, PROTO_PPP, 0, 0, 2, 1'b0);
        pkt_bytes[4] = 8'hFF;
        send_packet();
        stop_sending();
    endtask

    // More route entries than the entry counter can hold.
    task automatic test_route_count_saturation();
        build_packet(FLG_R | FLG_K, 16'h0800, 256, 0, 4, 1'b0);
        send_packet();
        stop_sending();
    endtask

    task automatic test_random_packets();
        int unsigned bytes_sent;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            build_random_packet();
            bytes_sent += pkt_bytes.size();
            send_packet();
        end
        stop_sending();
    endtask

    // Back-to-back words with the receiver always ready.
    task automatic test_steady_stream();
        int unsigned bytes_sent;
        bytes_sent  = 0;
        steady_flow = 1'b1;
        while (bytes_sent < 150) begin
            build_random_packet();
            bytes_sent += pkt_bytes.size();
            send_packet();
        end
        stop_sending();
        steady_flow = 1'b0;
    endtask

    // Short packets keep coming while the receiver holds off for a long time.
    task automatic test_output_backpressure();
        steady_flow  = 1'b1;
        hold_request = 1'b1;
        repeat (40) begin
            build_packet(16'h0000, 16'h0000, 0, 0, $urandom_range(0, 2), 1'b0);
            send_packet();
        end
        stop_sending();
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_header_corners();
        test_route_count_saturation();
        test_random_packets();
        test_steady_stream();
        test_output_backpressure();
        while (expected_summaries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: gre_header_parser.f
hdl/gre_hp_pkg.sv
hdl/gre_header_parser.sv
verif/gre_header_parser_test.sv
